@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the odometer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising clock, switched off while reset is asserted.
`define WTO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the rising clock, sampled through reset as well.
`define WTO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/wto_pkg.sv @@
// ----------------------------------------------------------------------------
// Wheel turn odometer package
// Field widths, angle thresholds, scale constants and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wto_pkg;

  // Field widths
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned RATE_W      = 17;
  localparam int unsigned RAD_W       = 18;
  localparam int unsigned OFF_W       = 32;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned DIST_W      = 43;
  localparam int unsigned SPEED_W     = 25;
  localparam int unsigned TURNS_W     = 21;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 96;

  // Default turn counter width
  localparam int unsigned TURN_BITS_DEF = 21;

  // Angle thresholds in 1/128 degree
  localparam logic [ANGLE_W-1:0] ANG_FULL = 16'd46080;  // 360 degrees
  localparam logic [ANGLE_W-1:0] ANG_HIGH = 16'd38400;  // 300 degrees
  localparam logic [ANGLE_W-1:0] ANG_LOW  = 16'd12800;  // 100 degrees

  // 2*pi/46080 as a 32-bit binary fraction
  localparam int unsigned SCALE_W   = 20;
  localparam logic [SCALE_W-1:0] SCALE_2PI = 20'd585635;
  localparam int unsigned FRAC_BITS = 32;

  // Speed: rate * radius / 1000; the magnitude of the product fits 34 bits
  localparam int unsigned SPEED_DIV = 1000;
  localparam int unsigned SPM_W     = 34;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_OFFSET    = 2'd1,
    CFG_NEG_DIST  = 2'd2,
    CFG_NEG_SPEED = 2'd3
  } cfg_idx_e;

  // Control of a bit-serial unit
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

endpackage

@@ rtl/core/wto_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wto_serial_mul import wto_pkg::*; #(
  parameter int unsigned MCAND_W = RAD_W + SCALE_W,
  parameter int unsigned MPLR_W  = RAD_W
) (
  input  logic                       clk_i,
  input  ser_ctl_t                   ctl_i,
  input  logic [MCAND_W-1:0]         mcand_i,  // held stable while stepping
  input  logic [MPLR_W-1:0]          mplr_i,   // taken on load
  output logic [MCAND_W+MPLR_W-1:0]  prod_o    // valid after MPLR_W steps
);

  localparam int unsigned PROD_W = MCAND_W + MPLR_W;

  logic [PROD_W:0]  p_q, p_d;
  logic [MCAND_W:0] sum;

  // Add the multiplicand to the upper half when the low bit is set, then
  // shift the whole product right by one.
  always_comb begin
    sum = p_q[PROD_W:MPLR_W] + (p_q[0] ? {1'b0, mcand_i} : {(MCAND_W+1){1'b0}});
    p_d = p_q;
    if (ctl_i.load) begin
      p_d = {{(MCAND_W+1){1'b0}}, mplr_i};
    end else if (ctl_i.step) begin
      p_d = {1'b0, sum, p_q[MPLR_W-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign prod_o = p_q[PROD_W-1:0];

endmodule

@@ rtl/core/wto_const_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial constant divider
// Restoring division by the speed divisor, one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wto_const_div import wto_pkg::*; #(
  parameter int unsigned DVD_W = SPM_W
) (
  input  logic             clk_i,
  input  ser_ctl_t         ctl_i,
  input  logic [DVD_W-1:0] dvd_i,  // taken on load
  output logic [DVD_W-1:0] quo_o   // valid after DVD_W steps
);

  localparam int unsigned REM_W = $clog2(SPEED_DIV);
  localparam logic [REM_W:0] DIVISOR = (REM_W+1)'(SPEED_DIV);

  logic [REM_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] dq_q, dq_d;
  logic [REM_W:0]   trial;
  logic             ge;

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, dq_q[DVD_W-1]};
    ge    = (trial >= DIVISOR);
    rem_d = rem_q;
    dq_d  = dq_q;
    if (ctl_i.load) begin
      rem_d = '0;
      dq_d  = dvd_i;
    end else if (ctl_i.step) begin
      rem_d = ge ? REM_W'(trial - DIVISOR) : trial[REM_W-1:0];
      dq_d  = {dq_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign quo_o = dq_q;

endmodule

@@ rtl/core/wheel_turn_odometer_unit.sv @@
// ----------------------------------------------------------------------------
// Wheel turn odometer
// Unwraps a wheel angle into a saturating turn count and reports distance,
// speed and turns for each sample, using bit-serial arithmetic.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction contents (lowest bits first)
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         angle_q7[15:0], wheel_rate_mrad_s[32:16]
//  m_axis    out        distance_um[42:0], speed_um_s[67:43], turns[88:68]
//  cfg       in         write of one register, index and data, no wait
//
//  Each sample passes through the sequencer states POS, KMUL, LOAD, DMUL,
//  FIN1 and FIN2 on its way to the result register, and the next sample
//  can be taken in the cycle after the result register is loaded. DMUL
//  runs the bit-serial distance multiplier, which walks one bit of the
//  position magnitude per cycle, after the radius scaling in KMUL. Reset
//  returns the turn state, the latches, the output valid flag, the sequencer
//  and the configuration registers to their reset values. A new sample is
//  taken as soon as the sequencer is idle, even while the previous result
//  waits at m_axis; a result stalled there holds the final step until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wheel_turn_odometer_unit import wto_pkg::*; #(
  parameter int unsigned TURN_BITS = TURN_BITS_DEF  // 8 to 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // angle_q7, wheel_rate_mrad_s

  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // distance_um, speed_um_s, turns

  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // Derived widths
  // --------------------------------------------------------------------------
  localparam int unsigned POS_W   = TURN_BITS + ANGLE_W + 1;  // signed position
  localparam int unsigned K_W     = RAD_W + SCALE_W;          // radius * scale
  localparam int unsigned PROD_W  = K_W + POS_W;              // |pos| * k
  localparam int unsigned Q_W     = PROD_W - FRAC_BITS;       // scaled magnitude
  localparam int unsigned D_W     = Q_W + 2;                  // signed difference
  localparam int unsigned SAT_W   = (D_W > DIST_W) ? D_W : DIST_W;
  localparam int unsigned SP_W    = RATE_W + 1 + RAD_W;       // speed product
  localparam int unsigned TX_W    = (TURN_BITS > TURNS_W) ? TURN_BITS : TURNS_W;
  localparam int unsigned STEPS_D = (POS_W > SPM_W) ? POS_W : SPM_W;
  localparam int unsigned CNT_W   = $clog2(STEPS_D + 1);

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  localparam logic signed [SAT_W-1:0] DIST_MAX =
    {{(SAT_W-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] DIST_MIN = ~DIST_MAX;

  localparam logic [SPM_W-1:0] SPEED_LIM = SPM_W'(2**(SPEED_W-1));

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a sample
  localparam logic [2:0] ST_POS  = 3'd1;  // form the angular position
  localparam logic [2:0] ST_KMUL = 3'd2;  // radius * scale, rate * radius
  localparam logic [2:0] ST_LOAD = 3'd3;  // prime the multiplier and divider
  localparam logic [2:0] ST_DMUL = 3'd4;  // |pos| * k, speed / 1000
  localparam logic [2:0] ST_FIN1 = 3'd5;  // round, sign, saturate speed
  localparam logic [2:0] ST_FIN2 = 3'd6;  // offset, saturate distance, emit

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]        radius_q;
  logic signed [OFF_W-1:0] offset_q;
  logic                    neg_dist_q;
  logic                    neg_spd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RAD_W'(50000);
      offset_q   <= '0;
      neg_dist_q <= 1'b0;
      neg_spd_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS:    radius_q   <= cfg_wdata_i[RAD_W-1:0];
        CFG_OFFSET:    offset_q   <= cfg_wdata_i[OFF_W-1:0];
        CFG_NEG_DIST:  neg_dist_q <= cfg_wdata_i[0];
        CFG_NEG_SPEED: neg_spd_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample acceptance and turn unwrapping
  // --------------------------------------------------------------------------
  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      in_acc;
  logic [ANGLE_W-1:0]        in_angle;
  logic signed [RATE_W-1:0]  in_rate;

  logic [ANGLE_W-1:0]           prev_angle_q, prev_angle_d;
  logic signed [TURN_BITS-1:0]  turn_cnt_q, turn_cnt_d;
  logic                         up_q, up_d, down_q, down_d;
  logic signed [RATE_W-1:0]     rate_q;
  logic                         up_hit, down_hit, rearm;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_angle      = s_axis_tdata[ANGLE_W-1:0];
  assign in_rate       = s_axis_tdata[ANGLE_W+RATE_W-1:ANGLE_W];

  // Forward wrap counts up, backward wrap counts down; each latch blocks a
  // second count in its direction until a rearm or a count the other way.
  always_comb begin
    up_hit   = (prev_angle_q > ANG_HIGH) && (prev_angle_q <= ANG_FULL) &&
               (in_angle < ANG_LOW);
    down_hit = (prev_angle_q < ANG_LOW) && (in_angle > ANG_HIGH) &&
               (in_angle <= ANG_FULL);
    rearm    = (in_angle > ANG_LOW) && (prev_angle_q < ANG_HIGH);

    prev_angle_d = prev_angle_q;
    turn_cnt_d   = turn_cnt_q;
    up_d         = up_q;
    down_d       = down_q;
    if (in_acc) begin
      prev_angle_d = in_angle;
      if (up_hit) begin
        if (!up_q) begin
          if (turn_cnt_q != TURN_MAX) begin
            turn_cnt_d = turn_cnt_q + TURN_BITS'(1);
          end
          up_d   = 1'b1;
          down_d = 1'b0;
        end
      end else if (down_hit) begin
        if (!down_q) begin
          if (turn_cnt_q != TURN_MIN) begin
            turn_cnt_d = turn_cnt_q - TURN_BITS'(1);
          end
          down_d = 1'b1;
          up_d   = 1'b0;
        end
      end else if (rearm) begin
        up_d   = 1'b0;
        down_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      turn_cnt_q   <= '0;
      up_q         <= 1'b0;
      down_q       <= 1'b0;
    end else begin
      prev_angle_q <= prev_angle_d;
      turn_cnt_q   <= turn_cnt_d;
      up_q         <= up_d;
      down_q       <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rate_q <= in_rate;
    end
  end

  // --------------------------------------------------------------------------
  // Angular position: turns * 46080 + angle, 46080 = 45 * 1024
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] turn_x;
  logic signed [POS_W-1:0] pos_q;
  logic [POS_W-1:0]        mag_q;
  logic                    pos_neg_q;

  assign turn_x = POS_W'(turn_cnt_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_POS) begin
      pos_q <= (turn_x <<< 15) + (turn_x <<< 13) + (turn_x <<< 12) +
               (turn_x <<< 10) + POS_W'(prev_angle_q);
    end
    // Take the magnitude while the scale product builds up
    if (state_q == ST_KMUL) begin
      pos_neg_q <= pos_q[POS_W-1];
      mag_q     <= pos_q[POS_W-1] ? POS_W'(-pos_q) : pos_q;
    end
  end

  // --------------------------------------------------------------------------
  // Serial units
  // --------------------------------------------------------------------------
  ser_ctl_t           kmul_ctl, dmul_ctl, div_ctl;
  logic [K_W-1:0]     k_prod;
  logic [PROD_W-1:0]  d_prod;
  logic [SPM_W-1:0]   spd_quo;

  always_comb begin
    kmul_ctl.load = (state_q == ST_POS);
    kmul_ctl.step = (state_q == ST_KMUL);
    dmul_ctl.load = (state_q == ST_LOAD);
    dmul_ctl.step = (state_q == ST_DMUL) && (cnt_q < CNT_W'(POS_W));
    div_ctl.load  = (state_q == ST_LOAD);
    div_ctl.step  = (state_q == ST_DMUL) && (cnt_q < CNT_W'(SPM_W));
  end

  // Radius times the 2*pi scale, one radius bit a cycle
  wto_serial_mul #(
    .MCAND_W (SCALE_W),
    .MPLR_W  (RAD_W)
  ) u_kmul (
    .clk_i   (clk_i),
    .ctl_i   (kmul_ctl),
    .mcand_i (SCALE_2PI),
    .mplr_i  (radius_q),
    .prod_o  (k_prod)
  );

  // Position magnitude times the scaled radius, one position bit a cycle
  wto_serial_mul #(
    .MCAND_W (K_W),
    .MPLR_W  (POS_W)
  ) u_dmul (
    .clk_i   (clk_i),
    .ctl_i   (dmul_ctl),
    .mcand_i (k_prod),
    .mplr_i  (mag_q),
    .prod_o  (d_prod)
  );

  // Signed rate times radius: arithmetic shift-add over the radius bits
  logic [SP_W-1:0]         sp_q, sp_d;
  logic signed [RATE_W:0]  sp_sum;
  logic [SP_W-1:0]         sp_mag;
  logic                    spd_neg_q;

  always_comb begin
    sp_sum = $signed(sp_q[SP_W-1:RAD_W]) +
             (sp_q[0] ? $signed((RATE_W+1)'(rate_q)) : $signed((RATE_W+1)'(0)));
    sp_d   = sp_q;
    if (state_q == ST_POS) begin
      sp_d = {{(RATE_W+1){1'b0}}, radius_q};
    end else if (state_q == ST_KMUL) begin
      sp_d = {sp_sum[RATE_W], sp_sum, sp_q[RAD_W-1:1]};
    end
    sp_mag = sp_q[SP_W-1] ? (~sp_q + SP_W'(1)) : sp_q;
  end

  always_ff @(posedge clk_i) begin
    sp_q <= sp_d;
    if (state_q == ST_LOAD) begin
      spd_neg_q <= sp_q[SP_W-1];
    end
  end

  // Speed magnitude divided by 1000, truncating toward zero once signed
  wto_const_div #(
    .DVD_W (SPM_W)
  ) u_div (
    .clk_i (clk_i),
    .ctl_i (div_ctl),
    .dvd_i (sp_mag[SPM_W-1:0]),
    .quo_o (spd_quo)
  );

  // --------------------------------------------------------------------------
  // Result shaping
  // --------------------------------------------------------------------------
  logic [Q_W-1:0]          q_mag;
  logic                    q_rnd;
  logic signed [Q_W:0]     sq_q;
  logic                    spd_fneg;
  logic                    spd_sat;
  logic [SPM_W-1:0]        spd_neg_val;
  logic [SPEED_W-1:0]      speed_res_q;

  // Floor of a negative product: round the magnitude up when any fraction
  // bit is set, and fold that into the two's complement.
  always_comb begin
    q_mag       = d_prod[PROD_W-1:FRAC_BITS];
    q_rnd       = pos_neg_q && (|d_prod[FRAC_BITS-1:0]);
    spd_fneg    = spd_neg_q ^ neg_spd_q;
    spd_sat     = spd_fneg ? (spd_quo > SPEED_LIM) : (spd_quo >= SPEED_LIM);
    spd_neg_val = ~spd_quo + SPM_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN1) begin
      sq_q <= pos_neg_q ? (~{1'b0, q_mag} + (Q_W+1)'(!q_rnd)) : {1'b0, q_mag};
      if (spd_sat) begin
        speed_res_q <= spd_fneg ? {1'b1, {(SPEED_W-1){1'b0}}}
                                : {1'b0, {(SPEED_W-1){1'b1}}};
      end else begin
        speed_res_q <= spd_fneg ? spd_neg_val[SPEED_W-1:0] : spd_quo[SPEED_W-1:0];
      end
    end
  end

  logic signed [D_W-1:0]   sq_x, off_x, dist_raw;
  logic signed [SAT_W-1:0] dist_x;
  logic [DIST_W-1:0]       dist_sat;
  logic signed [TX_W-1:0]  turn_ext;

  always_comb begin
    sq_x     = D_W'(sq_q);
    off_x    = D_W'(offset_q);
    dist_raw = neg_dist_q ? (off_x - sq_x) : (sq_x - off_x);
    dist_x   = SAT_W'(dist_raw);
    if (dist_x > DIST_MAX) begin
      dist_sat = DIST_MAX[DIST_W-1:0];
    end else if (dist_x < DIST_MIN) begin
      dist_sat = DIST_MIN[DIST_W-1:0];
    end else begin
      dist_sat = dist_x[DIST_W-1:0];
    end
    turn_ext = TX_W'(turn_cnt_q);
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                 out_valid_q;
  logic                 out_load;
  logic [DIST_W-1:0]    dist_o_q;
  logic [SPEED_W-1:0]   speed_o_q;
  logic [TURNS_W-1:0]   turns_o_q;

  // Emit only when the output register is empty or being drained
  assign out_load = (state_q == ST_FIN2) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dist_o_q  <= dist_sat;
      speed_o_q <= speed_res_q;
      turns_o_q <= turn_ext[TURNS_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-DIST_W-SPEED_W-TURNS_W)'(0),
                          turns_o_q, speed_o_q, dist_o_q};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        cnt_d   = '0;
        state_d = ST_KMUL;
      end
      ST_KMUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RAD_W - 1)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_DMUL;
      end
      ST_DMUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS_D - 1)) begin
          state_d = ST_FIN1;
        end
      end
      ST_FIN1: begin
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `WTO_ASSERT(a_accept_starts, clk_i, rst_ni, in_acc |=> (state_q == ST_POS), "accepted sample did not start the sequencer")
  `WTO_ASSERT(a_turns_only_on_accept, clk_i, rst_ni, !in_acc |=> $stable(turn_cnt_q), "turn count moved without a sample")
  `WTO_ASSERT(a_fin_after_mul, clk_i, rst_ni, (state_q == ST_FIN1) |-> ($past(state_q) == ST_DMUL), "result shaping entered before the serial multiply ended")
  `WTO_ASSERT(a_stall_holds_fin, clk_i, rst_ni, ((state_q == ST_FIN2) && out_valid_q && !m_axis_tready) |=> (state_q == ST_FIN2), "result overwrote a stalled transaction")
  `WTO_ASSERT_ALWAYS(a_latches_exclusive, clk_i, !rst_ni || !(up_q && down_q), "up and down latches both set")

endmodule

@@ dv/wheel_turn_odometer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Wheel turn odometer testbench
// Drives angle and rate samples into the odometer, predicts each result from
// its own model of the turn unwrap and the distance and speed arithmetic,
// and checks every result transaction in order under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel_turn_odometer_unit_tb;
  import wto_pkg::*;

  // Run the block with a narrow turn counter so that both saturation limits
  // (+127 and -128 turns) are reached within a run of normal length.
  localparam int unsigned TURN_CNT_W = 8;

  // Acceptance to result register, worked out from the sequencer states of the block.
  localparam int unsigned RESULT_LATENCY =
    22 + ((TURN_CNT_W + 17 > 34) ? TURN_CNT_W + 17 : 34);

  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 170;
  localparam int unsigned LONG_HOLD       = 800;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;

  // Phases that turn the wheel forwards; the rest turn it backwards.
  localparam bit [PHASES-1:0] FORWARD_PHASES = 10'b10_0000_0111;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [SPEED_W-1:0] speed;
    logic [TURNS_W-1:0] turns;
  } odo_result_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [RATE_W-1:0]  rate;
    logic               typed;    // 1: the result below is the expectation
    odo_result_t        result;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [1:0]             cfg_idx_i     = CFG_RADIUS;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wheel_turn_odometer_unit #(
    .TURN_BITS     (TURN_CNT_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Odometer model: turn state, latches and the register copies
  // --------------------------------------------------------------------------
  logic [ANGLE_W-1:0] wheel_prev_angle = '0;
  longint             wheel_turns      = 0;
  bit                 latch_up         = 1'b0;
  bit                 latch_down       = 1'b0;
  longint             radius_um        = 50000;
  longint             offset_um        = 0;
  bit                 flip_distance    = 1'b0;
  bit                 flip_speed       = 1'b0;

  odo_result_t        odo_results_q[$];   // expected results, oldest first
  int unsigned        mismatch_count   = 0;
  int unsigned        cycle_count      = 0;

  // Sender and receiver pacing
  bit                 sender_burst     = 1'b0;
  logic               long_hold_req    = 1'b0;
  bit                 long_hold_done   = 1'b0;
  int unsigned        hold_left        = 0;
  int unsigned        stall_left       = 0;
  int unsigned        rx_mode          = 0;
  int unsigned        rx_mode_left     = 0;

  function automatic logic signed [127:0] saturate_to(logic signed [127:0] v,
                                                      int unsigned w);
    logic signed [127:0] top;
    top = (128'sd1 <<< (w - 1)) - 128'sd1;
    if (v > top) return top;
    if (v < -top - 128'sd1) return -top - 128'sd1;
    return v;
  endfunction

  // Advance the turn state by one sample and work out its result.
  function automatic odo_result_t advance_wheel(logic [ANGLE_W-1:0] ang,
                                                logic [RATE_W-1:0] rate_raw);
    longint              tmax;
    longint              tmin;
    longint              pos;
    int unsigned         p;
    int unsigned         a;
    logic signed [127:0] dist_v;
    logic signed [127:0] spd;
    odo_result_t         res;
    tmax = (longint'(1) <<< (TURN_CNT_W - 1)) - 1;
    tmin = -tmax - 1;
    p    = wheel_prev_angle;
    a    = ang;

    // Unwrap: a high-to-low jump counts up, low-to-high counts down, and the
    // latches hold off a repeat count until a mid-turn rearm or a count the other way.
    if (p > ANG_HIGH && p <= ANG_FULL && a < ANG_LOW) begin
      if (!latch_up) begin
        if (wheel_turns < tmax) wheel_turns++;
        latch_up   = 1'b1;
        latch_down = 1'b0;
      end
    end else if (p < ANG_LOW && a > ANG_HIGH && a <= ANG_FULL) begin
      if (!latch_down) begin
        if (wheel_turns > tmin) wheel_turns--;
        latch_down = 1'b1;
        latch_up   = 1'b0;
      end
    end else if (a > ANG_LOW && p < ANG_HIGH) begin
      latch_up   = 1'b0;
      latch_down = 1'b0;
    end
    wheel_prev_angle = ang;

    // Distance: position times radius times the 2*pi scale, floored.
    pos    = wheel_turns * longint'(ANG_FULL) + longint'(a);
    dist_v = pos;
    dist_v = dist_v * (radius_um * longint'(SCALE_2PI));
    dist_v = (dist_v >>> FRAC_BITS) - offset_um;
    if (flip_distance) dist_v = -dist_v;
    dist_v = saturate_to(dist_v, DIST_W);

    // Speed: truncated towards zero.
    spd = (longint'($signed(rate_raw)) * radius_um) / 64'sd1000;
    if (flip_speed) spd = -spd;
    spd = saturate_to(spd, SPEED_W);

    res.distance = dist_v[DIST_W-1:0];
    res.speed    = spd[SPEED_W-1:0];
    res.turns    = wheel_turns[TURNS_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Configuration writes; only issued while the block is idle
  // --------------------------------------------------------------------------
  // Drive one write and mirror it into the model copy; write enable is left
  // high so that back-to-back writes do not toggle it within a time step.
  task automatic put_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_RADIUS:    radius_um     = longint'(val[RAD_W-1:0]);
      CFG_OFFSET:    offset_um     = longint'($signed(val[OFF_W-1:0]));
      CFG_NEG_DIST:  flip_distance = val[0];
      CFG_NEG_SPEED: flip_speed    = val[0];
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [CFG_W-1:0] radius_w, logic [CFG_W-1:0] offset_w,
                            logic [CFG_W-1:0] neg_dist_w, logic [CFG_W-1:0] neg_speed_w);
    put_reg(CFG_RADIUS, radius_w);
    put_reg(CFG_OFFSET, offset_w);
    put_reg(CFG_NEG_DIST, neg_dist_w);
    put_reg(CFG_NEG_SPEED, neg_speed_w);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sample sender
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_burst) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Offer one sample, wait for its transaction, queue the expectation, then
  // idle for a random gap. With no gap valid stays high for the next sample.
  task automatic send_sample(logic [ANGLE_W-1:0] ang, logic [RATE_W-1:0] rate,
                             logic typed, odo_result_t typed_res);
    odo_result_t res;
    int unsigned gap;
    s_axis_tdata  <= {{(IN_TDATA_W - ANGLE_W - RATE_W){1'b0}}, rate, ang};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    res = advance_wheel(ang, rate);
    odo_results_q.push_back(typed ? typed_res : res);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain_results();
    while (odo_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed samples under the reset register values. Rows marked typed carry
  // their result written out; the others are worked out by the model.
  stim_row_t directed_rows [19] = '{
    // both zero straight after reset
    '{16'd0,     17'd0,        1'b1, '{43'sd0, 25'sd0,        21'sd0}},
    // low-to-high jump counts down; largest positive rate
    '{16'd46080, 17'd65535,    1'b1, '{43'sd0, 25'sd3276750,  -21'sd1}},
    // high-to-low jump counts up; most negative rate
    '{16'd0,     17'h10000,    1'b1, '{43'sd0, -25'sd3276800, 21'sd0}},
    '{16'd46080, 17'd1,        1'b1, '{43'sd0, 25'sd50,       -21'sd1}},
    // exactly 100 degrees does not rearm
    '{16'd12800, 17'h1FFFF,    1'b0, '0},
    '{16'd5000,  17'd0,        1'b0, '0},
    // down latch still set: this jump must not count
    '{16'd40000, 17'd40000,    1'b0, '0},
    '{16'd20000, -17'sd40000,  1'b0, '0},
    '{16'd39000, 17'd0,        1'b0, '0},
    '{16'd12799, 17'd0,        1'b0, '0},
    '{16'd12801, 17'd0,        1'b0, '0},
    '{16'd38401, 17'd0,        1'b0, '0},
    // angles beyond a full turn
    '{16'd46081, 17'd0,        1'b0, '0},
    '{16'd0,     17'd0,        1'b0, '0},
    '{16'd65535, 17'd0,        1'b0, '0},
    '{16'd100,   17'd0,        1'b0, '0},
    '{16'd38400, 17'd0,        1'b0, '0},
    '{16'd46080, 17'd0,        1'b0, '0},
    '{16'd0,     17'd0,        1'b0, '0}
  };

  logic [ANGLE_W-1:0] corner_angles [11] = '{
    16'd0, 16'd12799, 16'd12800, 16'd12801, 16'd38399, 16'd38400,
    16'd38401, 16'd46079, 16'd46080, 16'd46081, 16'd65535
  };

  logic [RATE_W-1:0] corner_rates [7] = '{
    17'd0, 17'd1, 17'h1FFFF, 17'h0FFFF, 17'h10000, 17'd40000, -17'sd40000
  };

  initial begin
    int unsigned        r;
    int                 walk_angle;
    int                 step;
    int                 rate_val;
    logic [ANGLE_W-1:0] ang;
    logic [RATE_W-1:0]  rate;

    walk_angle = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, registers at their reset values.
    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].angle, directed_rows[i].rate,
                  directed_rows[i].typed, directed_rows[i].result);
    end
    s_axis_tvalid <= 1'b0;
    drain_results();

    // Random part: each phase sets the registers while idle, then turns the
    // wheel in one direction with random steps, mixed with corner and noise
    // angles. The direction pattern drives the counter into both limits.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_regs(32'd50000, 32'd0, 32'd0, 32'd0);
        1:       write_regs(32'd0, 32'h8000_0000, 32'd1, 32'd1);
        2:       write_regs(32'd262143, 32'h7FFF_FFFF, 32'd0, 32'd0);
        3:       write_regs(32'd262143, 32'h8000_0000, 32'd1, 32'd1);
        default: write_regs($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      // Ask the receiver for one long hold-off while samples keep coming.
      if (ph == 2) long_hold_req <= 1'b1;
      sender_burst = ($urandom_range(3) == 0);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(99);
        if (r < 80) begin
          step       = $urandom_range(12000, 23000);
          walk_angle = FORWARD_PHASES[ph] ? walk_angle + step : walk_angle - step;
          if (walk_angle >= int'(ANG_FULL)) walk_angle -= int'(ANG_FULL);
          else if (walk_angle < 0) walk_angle += int'(ANG_FULL);
          ang = walk_angle[ANGLE_W-1:0];
        end else if (r < 90) begin
          ang = corner_angles[4'($urandom_range(10))];
        end else begin
          ang = ANGLE_W'($urandom_range(65535));
        end

        r = $urandom_range(99);
        if (r < 60) begin
          rate_val = int'($urandom_range(80000)) - 40000;
          rate     = rate_val[RATE_W-1:0];
        end else if (r < 80) begin
          rate = RATE_W'($urandom_range(131071));
        end else begin
          rate = corner_rates[3'($urandom_range(6))];
        end
        send_sample(ang, rate, 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (RESULT_LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && odo_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result receiver: check each transaction, then pace tready
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_rx
    odo_result_t got;
    odo_result_t want;
    got.distance = m_axis_tdata[DIST_W-1:0];
    got.speed    = m_axis_tdata[DIST_W+SPEED_W-1:DIST_W];
    got.turns    = m_axis_tdata[DIST_W+SPEED_W+TURNS_W-1:DIST_W+SPEED_W];

    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (odo_results_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result distance %0d speed %0d turns %0d",
                                $signed(got.distance), $signed(got.speed),
                                $signed(got.turns)));
      end else begin
        want = odo_results_q.pop_front();
        if (got.distance !== want.distance || got.speed !== want.speed ||
            got.turns !== want.turns) begin
          note_mismatch($sformatf(
            "distance exp %0d got %0d, speed exp %0d got %0d, turns exp %0d got %0d",
            $signed(want.distance), $signed(got.distance),
            $signed(want.speed), $signed(got.speed),
            $signed(want.turns), $signed(got.turns)));
        end
      end
    end

    // Swap between an always-ready stretch and random stalls now and then.
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(2);
      rx_mode_left = $urandom_range(300, 700);
    end else begin
      rx_mode_left--;
    end

    // Pick up a long hold-off request once; the block fills and stalls its input.
    if (long_hold_req && !long_hold_done) begin
      hold_left      = LONG_HOLD;
      long_hold_done = 1'b1;
    end

    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < 25) begin
      // Mostly short stalls, now and then a long one.
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(19, 99) : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
